FILE: rtl/sparse_crs_zero_row_compaction_core_macros.svh
// Assertion macros used by the sparse row compaction RTL.
`ifndef SPARSE_CRS_ZERO_ROW_COMPACTION_CORE_MACROS_SVH
`define SPARSE_CRS_ZERO_ROW_COMPACTION_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define SCRC_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("scrc: assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define SCRC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("scrc: assertion failed");

`endif

FILE: rtl/scrc_pkg.sv
// Types, constants and helpers for the sparse row compaction block.
package scrc_pkg;

	localparam int unsigned DEF_MAX_ROWS    = 4096;
	localparam int unsigned DEF_MAX_ENTRIES = 1048576;

	localparam int OPCODE_W   = 2;
	localparam int IDX_W      = 12;
	localparam int VALUE_W    = 64;
	localparam int NUM_ROWS_W = 13;
	localparam int ENTRY_W    = 20;
	localparam int NNZ_W      = 21;

	localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = 13'd4096;

	typedef enum logic [OPCODE_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_SCAN   = 2'd1,
		OP_FINISH = 2'd2,
		OP_EMIT   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_FIN,
		ST_EMIT
	} state_t;

	typedef enum logic {
		KIND_ENTRY   = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                   kind;
		logic [IDX_W-1:0]        new_row;
		logic [IDX_W-1:0]        new_col;
		logic [VALUE_W-1:0]      value_out;
		logic [ENTRY_W-1:0]      entry_index;
		logic                    row_start;
		logic [NUM_ROWS_W-1:0]   kept_rows;
		logic [NNZ_W-1:0]        nnz_total;
	} result_t;

	// plus or minus zero
	function automatic logic is_zero(input logic [VALUE_W-1:0] bits);
		return bits[VALUE_W-2:0] == '0;
	endfunction

endpackage

FILE: rtl/scrc_out_reg.sv
// Output register holding one result until the consumer takes it.
module scrc_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  scrc_pkg::result_t d,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output scrc_pkg::result_t q
);
	import scrc_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign q         = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

endmodule

FILE: rtl/sparse_crs_zero_row_compaction_core.sv
// An emit result is registered from ST_EMIT once the output slot is free; scan and clear give none.
// One scan per cycle while idle; an emit keeps in_ready low through ST_EMIT (mark and prefix memory read).
// Finish walks the mark memory, one row a cycle, then gives the summary from ST_FIN.
// Clear sweeps every row of the mark memory, in_ready low meanwhile.
// Reset: async, active low; runs the same sweep before the first item.
`include "sparse_crs_zero_row_compaction_core_macros.svh"

module sparse_crs_zero_row_compaction_core #(
	parameter int unsigned MAX_ROWS    = scrc_pkg::DEF_MAX_ROWS,
	parameter int unsigned MAX_ENTRIES = scrc_pkg::DEF_MAX_ENTRIES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [scrc_pkg::NUM_ROWS_W-1:0]  num_rows,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [scrc_pkg::OPCODE_W-1:0]    opcode,
	input  logic [scrc_pkg::IDX_W-1:0]       row,
	input  logic [scrc_pkg::IDX_W-1:0]       col,
	input  logic [scrc_pkg::VALUE_W-1:0]     value_bits,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             kind,
	output logic [scrc_pkg::IDX_W-1:0]       new_row,
	output logic [scrc_pkg::IDX_W-1:0]       new_col,
	output logic [scrc_pkg::VALUE_W-1:0]     value_out,
	output logic [scrc_pkg::ENTRY_W-1:0]     entry_index,
	output logic                             row_start,
	output logic [scrc_pkg::NUM_ROWS_W-1:0]  kept_rows,
	output logic [scrc_pkg::NNZ_W-1:0]       nnz_total
);
	import scrc_pkg::*;

	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int CNT_W = $clog2(MAX_ROWS + 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAX_ROWS - 1);
	localparam logic [NNZ_W-1:0] NNZ_LIMIT =
		NNZ_W'((MAX_ENTRIES < 32'h1FFFFF) ? MAX_ENTRIES : 32'h1FFFFF);
	localparam logic [ENTRY_W-1:0] IDX_LIMIT =
		ENTRY_W'(((MAX_ENTRIES - 1) < 32'hFFFFF) ? (MAX_ENTRIES - 1) : 32'hFFFFF);

	state_t state_q, state_d;
	opcode_t op;
	logic accept;

	logic [NUM_ROWS_W-1:0] num_rows_q;
	logic [31:0]           n32;
	logic                  row_ok, nz;
	logic [ROW_W-1:0]      row_ix, col_ix;

	logic [ROW_W-1:0] clr_cnt_q, walk_cnt_q, walk_idx_s1;
	logic             walk_v_s1;
	logic [CNT_W-1:0] empties_q;

	logic [NNZ_W-1:0]   nnz_q;
	logic [ENTRY_W-1:0] emit_cnt_q;
	logic [IDX_W-1:0]   last_row_q;
	logic               any_emit_q;

	logic [IDX_W-1:0]   row_s1, col_s1;
	logic [VALUE_W-1:0] val_s1;
	logic               hit_s1;
	logic               emit_hit;

	// row marks and empty-rows-below prefix table
	logic             mark_mem [MAX_ROWS];
	logic [CNT_W-1:0] erb_mem  [MAX_ROWS];
	logic             mark_we, mark_wd, mark_re, mark_rd_q;
	logic [ROW_W-1:0] mark_wa, mark_ra;
	logic             erb_re;
	logic [CNT_W-1:0] erb_row_rd_q, erb_col_rd_q;

	logic    res_free, res_load;
	result_t res_d, res_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign op        = opcode_t'(opcode);

	assign n32    = (32'(num_rows_q) > MAX_ROWS) ? MAX_ROWS : 32'(num_rows_q);
	assign row_ok = 32'(row) < n32;
	assign nz     = !is_zero(value_bits);
	assign row_ix = ROW_W'(row);
	assign col_ix = (32'(col) < MAX_ROWS) ? ROW_W'(col) : LAST_ROW;

	always_comb begin
		mark_we = 1'b0;
		mark_wa = clr_cnt_q;
		mark_wd = 1'b0;
		if (state_q == ST_CLEAR) begin
			mark_we = 1'b1;
		end else if (accept && op == OP_SCAN && row_ok && nz) begin
			mark_we = 1'b1;
			mark_wa = row_ix;
			mark_wd = 1'b1;
		end
		mark_re = (accept && op == OP_EMIT) || state_q == ST_WALK;
		mark_ra = (state_q == ST_WALK) ? walk_cnt_q : row_ix;
		erb_re  = accept && op == OP_EMIT;
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_wa] <= mark_wd;
		end
		if (mark_re) begin
			mark_rd_q <= mark_mem[mark_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (walk_v_s1) begin
			erb_mem[walk_idx_s1] <= empties_q;
		end
		if (erb_re) begin
			erb_row_rd_q <= erb_mem[row_ix];
			erb_col_rd_q <= erb_mem[col_ix];
		end
	end

	assign emit_hit = hit_s1 && mark_rd_q;

	always_comb begin
		res_load          = 1'b0;
		res_d             = '0;
		res_d.kind        = KIND_ENTRY;
		res_d.new_row     = row_s1 - IDX_W'(erb_row_rd_q);
		res_d.new_col     = col_s1 - IDX_W'(erb_col_rd_q);
		res_d.value_out   = val_s1;
		res_d.entry_index = emit_cnt_q;
		res_d.row_start   = !any_emit_q || row_s1 != last_row_q;
		state_d           = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == LAST_ROW) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (op)
						OP_CLEAR:  state_d = ST_CLEAR;
						OP_FINISH: state_d = ST_WALK;
						OP_EMIT:   state_d = ST_EMIT;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_WALK: begin
				if (walk_cnt_q == LAST_ROW) state_d = ST_FIN;
			end
			ST_FIN: begin
				// last walk stage must land in empties_q first
				if (!walk_v_s1 && res_free) begin
					res_load        = 1'b1;
					res_d           = '0;
					res_d.kind      = KIND_SUMMARY;
					res_d.kept_rows = NUM_ROWS_W'(n32 - 32'(empties_q));
					res_d.nnz_total = nnz_q;
					state_d         = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (!emit_hit) begin
					state_d = ST_IDLE;
				end else if (res_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= NUM_ROWS_RST;
			clr_cnt_q  <= '0;
			walk_cnt_q <= '0;
			walk_v_s1  <= 1'b0;
			empties_q  <= '0;
			nnz_q      <= '0;
			emit_cnt_q <= '0;
			last_row_q <= '0;
			any_emit_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				num_rows_q <= num_rows;
			end
			clr_cnt_q  <= (state_q == ST_CLEAR) ? clr_cnt_q + 1'b1 : '0;
			walk_cnt_q <= (state_q == ST_WALK) ? walk_cnt_q + 1'b1 : '0;
			walk_v_s1  <= (state_q == ST_WALK);

			if (accept && op == OP_FINISH) begin
				empties_q <= '0;
			end else if (walk_v_s1 && 32'(walk_idx_s1) < n32 && !mark_rd_q) begin
				empties_q <= empties_q + 1'b1;
			end

			if (accept && op == OP_CLEAR) begin
				nnz_q <= '0;
			end else if (accept && op == OP_SCAN && row_ok && nz && nnz_q < NNZ_LIMIT) begin
				nnz_q <= nnz_q + 1'b1;
			end

			if (accept && (op == OP_CLEAR || op == OP_FINISH)) begin
				emit_cnt_q <= '0;
				any_emit_q <= 1'b0;
				if (op == OP_CLEAR) last_row_q <= '0;
			end else if (state_q == ST_EMIT && res_load) begin
				if (emit_cnt_q < IDX_LIMIT) emit_cnt_q <= emit_cnt_q + 1'b1;
				last_row_q <= row_s1;
				any_emit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		walk_idx_s1 <= walk_cnt_q;
		if (accept && op == OP_EMIT) begin
			row_s1 <= row;
			col_s1 <= col;
			val_s1 <= value_bits;
			hit_s1 <= row_ok && nz;
		end
	end

	scrc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.d         (res_d),
		.free      (res_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.q         (res_q)
	);

	assign kind        = res_q.kind;
	assign new_row     = res_q.new_row;
	assign new_col     = res_q.new_col;
	assign value_out   = res_q.value_out;
	assign entry_index = res_q.entry_index;
	assign row_start   = res_q.row_start;
	assign kept_rows   = res_q.kept_rows;
	assign nnz_total   = res_q.nnz_total;

	`SCRC_ASSERT_SAME(a_load_needs_slot, res_load, !out_valid || out_ready)
	`SCRC_ASSERT_SAME(a_walk_stage_state, walk_v_s1, state_q == ST_WALK || state_q == ST_FIN)
	`SCRC_ASSERT_SAME(a_nnz_bound, 1'b1, nnz_q <= NNZ_LIMIT)
	`SCRC_ASSERT_NEXT(a_emit_gives_entry, state_q == ST_EMIT && res_load,
		out_valid && kind == KIND_ENTRY)

endmodule
